@@ hw/rtl/ball_motion_predictor_top_assert.svh @@
// ----------------------------------------------------------------------------
// ball motion predictor assertion macros
// concurrent checks, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef BALL_MOTION_PREDICTOR_TOP_ASSERT_SVH
`define BALL_MOTION_PREDICTOR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define BMP_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
`define BMP_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define BMP_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define BMP_ASSERT_NXT(lbl, ck, rn, ante, cons, msg)
`endif

`endif

@@ hw/rtl/bmp_pkg.sv @@
// ----------------------------------------------------------------------------
// ball motion predictor package
// fixed-point constants, stage payload types and saturation helper
// ----------------------------------------------------------------------------
package bmp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DEC_W     = 21;
  localparam int TD_W      = 31 + DEC_W;
  localparam int W_W       = 32 + FRAC_BITS + 1;
  localparam int PL_W      = 31 + 32;
  localparam int PH_W      = 31 + W_W - 32;
  localparam int PROD_W    = 31 + W_W;
  localparam int MD_W      = PROD_W - (2 * FRAC_BITS + 1);
  localparam int CAP_BITS  = 34;
  localparam logic [DEC_W-1:0] DEC_RESET = 21'd11796;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               sx;
    logic               sy;
    logic [31:0]        ax;
    logic [31:0]        ay;
    logic [30:0]        tr;
    logic               clamped;
    logic [TD_W-1:0]    td;
  } sq_pay_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               sx;
    logic               sy;
    logic [31:0]        ax;
    logic [31:0]        ay;
    logic               clamped;
    logic [31:0]        s0;
    logic               stop;
    logic               zero;
    logic [31:0]        spd;
    logic [MD_W-1:0]    mdist;
  } dv_pay_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               sx;
    logic               sy;
    logic               clamped;
    logic               stop;
    logic               zero;
  } al_pay_t;

  function automatic logic [31:0] sat32(input logic signed [35:0] v);
    logic [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -36'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/bmp_sqrt.sv @@
// ----------------------------------------------------------------------------
// bmp_sqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module bmp_sqrt #(
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [63:0]   in_rad,
  input  logic [PW-1:0] in_pay,
  output logic          out_vld,
  output logic [31:0]   out_root,
  output logic [PW-1:0] out_pay
);
  localparam int STEPS = 32;

  logic          vld_r  [STEPS];
  logic [34:0]   rem_r  [STEPS];
  logic [31:0]   root_r [STEPS];
  logic [63:0]   rad_r  [STEPS];
  logic [PW-1:0] pay_r  [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic          cur_vld;
    logic [34:0]   cur_rem;
    logic [31:0]   cur_root;
    logic [63:0]   cur_rad;
    logic [PW-1:0] cur_pay;
    logic [34:0]   rem_sh;
    logic [34:0]   trial;
    logic          take;

    if (k == 0) begin : g_first
      assign cur_vld  = in_vld;
      assign cur_rem  = '0;
      assign cur_root = '0;
      assign cur_rad  = in_rad;
      assign cur_pay  = in_pay;
    end else begin : g_next
      assign cur_vld  = vld_r[k-1];
      assign cur_rem  = rem_r[k-1];
      assign cur_root = root_r[k-1];
      assign cur_rad  = rad_r[k-1];
      assign cur_pay  = pay_r[k-1];
    end

    // bring down two radicand bits, try 4*root+1
    assign rem_sh = {cur_rem[32:0], cur_rad[63:62]};
    assign trial  = {1'b0, cur_root, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= take ? (rem_sh - trial) : rem_sh;
        root_r[k] <= {cur_root[30:0], take};
        rad_r[k]  <= {cur_rad[61:0], 2'b00};
        pay_r[k]  <= cur_pay;
      end
    end
  end

  assign out_vld  = vld_r[STEPS-1];
  assign out_root = root_r[STEPS-1];
  assign out_pay  = pay_r[STEPS-1];

endmodule

@@ hw/rtl/bmp_div.sv @@
// ----------------------------------------------------------------------------
// bmp_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module bmp_div #(
  parameter int QW = 34,
  parameter int DW = 32,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [DW-1:0] in_rem,   // upper numerator part, below the divisor
  input  logic [QW-1:0] in_num,   // lower numerator bits
  input  logic [DW-1:0] in_den,
  input  logic [PW-1:0] in_pay,
  output logic          out_vld,
  output logic [QW-1:0] out_quo,
  output logic [PW-1:0] out_pay
);

  logic          vld_r [QW];
  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] nq_r  [QW];
  logic [DW-1:0] den_r [QW];
  logic [PW-1:0] pay_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic          cur_vld;
    logic [DW-1:0] cur_rem;
    logic [QW-1:0] cur_nq;
    logic [DW-1:0] cur_den;
    logic [PW-1:0] cur_pay;
    logic [DW:0]   rem_sh;
    logic [DW:0]   diff;
    logic          take;

    if (k == 0) begin : g_first
      assign cur_vld = in_vld;
      assign cur_rem = in_rem;
      assign cur_nq  = in_num;
      assign cur_den = in_den;
      assign cur_pay = in_pay;
    end else begin : g_next
      assign cur_vld = vld_r[k-1];
      assign cur_rem = rem_r[k-1];
      assign cur_nq  = nq_r[k-1];
      assign cur_den = den_r[k-1];
      assign cur_pay = pay_r[k-1];
    end

    assign rem_sh = {cur_rem, cur_nq[QW-1]};
    assign diff   = rem_sh - {1'b0, cur_den};
    assign take   = (rem_sh >= {1'b0, cur_den});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= cur_vld;
      end
    end

    // numerator shifts out the top, quotient bits fill in at the bottom
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= take ? diff[DW-1:0] : rem_sh[DW-1:0];
        nq_r[k]  <= {cur_nq[QW-2:0], take};
        den_r[k] <= cur_den;
        pay_r[k] <= cur_pay;
      end
    end
  end

  assign out_vld = vld_r[QW-1];
  assign out_quo = nq_r[QW-1];
  assign out_pay = pay_r[QW-1];

endmodule

@@ hw/rtl/ball_motion_predictor_top.sv @@
// ----------------------------------------------------------------------------
// ball_motion_predictor_top
// constant-deceleration position and velocity prediction, Q16.16
// depth: 139 register stages
// throughput: one word per cycle; the whole pipeline advances together
// and holds only while the output register is full and not taken
// reset: synchronous active-low, clears valid bits, deceleration = 11796
// ----------------------------------------------------------------------------
`include "ball_motion_predictor_top_assert.svh"

module ball_motion_predictor_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_wr_en,
  input  logic [20:0]    cfg_wr_data,   // deceleration
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [159:0]   in_tdata,      // pos_x, pos_y, vel_x, vel_y, elapsed
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [127:0]   out_tdata,     // pred_pos_x, pred_pos_y, pred_vel_x, pred_vel_y
  output logic [1:0]     out_tuser      // time_clamped, stopped
);
  import bmp_pkg::*;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               sx;
    logic               sy;
    logic [31:0]        ax;
    logic [31:0]        ay;
    logic [30:0]        tr;
    logic               clamped;
  } front_t;

  localparam int SQ_PW = $bits(sq_pay_t);
  localparam int DV_PW = $bits(dv_pay_t);
  localparam int AL_PW = $bits(al_pay_t);
  localparam int LANES = 4;

  logic             adv;
  logic [DEC_W-1:0] dec_r;

  // ---------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r <= DEC_RESET;
    end else if (cfg_wr_en) begin
      dec_r <= cfg_wr_data;
    end
  end

  // output register full and stalled freezes every stage
  logic         out_tvalid_r;
  logic [127:0] out_tdata_r;
  logic [1:0]   out_tuser_r;

  assign adv       = !out_tvalid_r || out_tready;
  assign in_tready = adv;

  // ---------------- t1: split, abs, clamp
  logic        t1_vld_r;
  front_t      t1_r;
  front_t      t1_nxt;
  logic [31:0] vx_in, vy_in, t_in;

  assign vx_in = in_tdata[95:64];
  assign vy_in = in_tdata[127:96];
  assign t_in  = in_tdata[159:128];

  always_comb begin
    t1_nxt.px      = in_tdata[31:0];
    t1_nxt.py      = in_tdata[63:32];
    t1_nxt.sx      = vx_in[31];
    t1_nxt.sy      = vy_in[31];
    t1_nxt.ax      = vx_in[31] ? (32'd0 - vx_in) : vx_in;
    t1_nxt.ay      = vy_in[31] ? (32'd0 - vy_in) : vy_in;
    t1_nxt.clamped = t_in[31];
    t1_nxt.tr      = t_in[31] ? 31'd0 : t_in[30:0];
  end

  // ---------------- t2: squares and t*a
  logic        t2_vld_r;
  sq_pay_t     t2_r;
  logic [63:0] t2_sqx_r, t2_sqy_r;

  // ---------------- t3: radicand
  logic        t3_vld_r;
  sq_pay_t     t3_r;
  logic [63:0] t3_rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_vld_r <= 1'b0;
      t2_vld_r <= 1'b0;
      t3_vld_r <= 1'b0;
    end else if (adv) begin
      t1_vld_r <= in_tvalid;
      t2_vld_r <= t1_vld_r;
      t3_vld_r <= t2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_r         <= t1_nxt;
      t2_r.px      <= t1_r.px;
      t2_r.py      <= t1_r.py;
      t2_r.sx      <= t1_r.sx;
      t2_r.sy      <= t1_r.sy;
      t2_r.ax      <= t1_r.ax;
      t2_r.ay      <= t1_r.ay;
      t2_r.tr      <= t1_r.tr;
      t2_r.clamped <= t1_r.clamped;
      t2_r.td      <= TD_W'(t1_r.tr) * TD_W'(dec_r);
      t2_sqx_r     <= 64'(t1_r.ax) * 64'(t1_r.ax);
      t2_sqy_r     <= 64'(t1_r.ay) * 64'(t1_r.ay);
      t3_r         <= t2_r;
      t3_rad_r     <= t2_sqx_r + t2_sqy_r;
    end
  end

  // ---------------- speed magnitude
  logic             sq_vld;
  logic [31:0]      sq_root;
  logic [SQ_PW-1:0] sq_pay_raw;
  sq_pay_t          sq_pay;

  bmp_sqrt #(.PW(SQ_PW)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (t3_vld_r),
    .in_rad   (t3_rad_r),
    .in_pay   (t3_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_pay  (sq_pay_raw)
  );
  assign sq_pay = sq_pay_raw;

  // ---------------- t4: stop test, moving speed, s0^2
  logic           t4_vld_r;
  dv_pay_t        t4_r;
  dv_pay_t        t4_nxt;
  logic [63:0]    t4_sq0_r;
  logic [W_W-1:0] t4_w_r;
  logic [30:0]    t4_tr_r;

  always_comb begin
    t4_nxt.px      = sq_pay.px;
    t4_nxt.py      = sq_pay.py;
    t4_nxt.sx      = sq_pay.sx;
    t4_nxt.sy      = sq_pay.sy;
    t4_nxt.ax      = sq_pay.ax;
    t4_nxt.ay      = sq_pay.ay;
    t4_nxt.clamped = sq_pay.clamped;
    t4_nxt.s0      = sq_root;
    t4_nxt.zero    = (sq_root == 32'd0);
    t4_nxt.stop    = (64'(sq_pay.td) >= (64'(sq_root) << FRAC_BITS));
    t4_nxt.spd     = sq_root - sq_pay.td[FRAC_BITS +: 32];
    t4_nxt.mdist   = '0;
  end

  // ---------------- t5: partial products of t * w
  logic            t5_vld_r;
  dv_pay_t         t5_r;
  logic [63:0]     t5_sq0_r;
  logic [PL_W-1:0] t5_pl_r;
  logic [PH_W-1:0] t5_ph_r;

  // ---------------- t6: moving distance
  logic              t6_vld_r;
  dv_pay_t           t6_r;
  dv_pay_t           t6_nxt;
  logic [63:0]       t6_sq0_r;
  logic [PROD_W-1:0] t6_prod;

  assign t6_prod = PROD_W'(t5_pl_r) + (PROD_W'(t5_ph_r) << 32);

  always_comb begin
    t6_nxt       = t5_r;
    t6_nxt.mdist = t6_prod[PROD_W-1 -: MD_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t4_vld_r <= 1'b0;
      t5_vld_r <= 1'b0;
      t6_vld_r <= 1'b0;
    end else if (adv) begin
      t4_vld_r <= sq_vld;
      t5_vld_r <= t4_vld_r;
      t6_vld_r <= t5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t4_r       <= t4_nxt;
      t4_sq0_r   <= 64'(sq_root) * 64'(sq_root);
      t4_w_r     <= W_W'((64'(sq_root) << (FRAC_BITS + 1)) - 64'(sq_pay.td));
      t4_tr_r    <= sq_pay.tr;
      t5_r       <= t4_r;
      t5_sq0_r   <= t4_sq0_r;
      t5_pl_r    <= PL_W'(t4_tr_r) * PL_W'(t4_w_r[31:0]);
      t5_ph_r    <= PH_W'(t4_tr_r) * PH_W'(t4_w_r[W_W-1:32]);
      t6_r       <= t6_nxt;
      t6_sq0_r   <= t5_sq0_r;
    end
  end

  // ---------------- stopping distance s0^2 / 2a
  logic             dv_vld;
  logic [63:0]      dv_quo;
  logic [DV_PW-1:0] dv_pay_raw;
  dv_pay_t          dv_pay;

  bmp_div #(.QW(64), .DW(DEC_W + 1), .PW(DV_PW)) u_stop_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (t6_vld_r),
    .in_rem  ('0),
    .in_num  (t6_sq0_r),
    .in_den  ({dec_r, 1'b0}),
    .in_pay  (t6_r),
    .out_vld (dv_vld),
    .out_quo (dv_quo),
    .out_pay (dv_pay_raw)
  );
  assign dv_pay = dv_pay_raw;

  // ---------------- a1: lane products m * d
  // lanes: vel x, vel y, pos x, pos y
  logic [31:0] ln_m [LANES];
  logic [63:0] ln_d [LANES];
  logic [63:0] spd_sel, dist_sel;
  al_pay_t     al_nxt;

  assign spd_sel  = dv_pay.stop ? 64'd0 : 64'(dv_pay.spd);
  assign dist_sel = dv_pay.stop ? dv_quo : 64'(dv_pay.mdist);
  assign ln_m[0]  = dv_pay.ax;
  assign ln_m[1]  = dv_pay.ay;
  assign ln_m[2]  = dv_pay.ax;
  assign ln_m[3]  = dv_pay.ay;
  assign ln_d[0]  = spd_sel;
  assign ln_d[1]  = spd_sel;
  assign ln_d[2]  = dist_sel;
  assign ln_d[3]  = dist_sel;

  always_comb begin
    al_nxt.px      = dv_pay.px;
    al_nxt.py      = dv_pay.py;
    al_nxt.sx      = dv_pay.sx;
    al_nxt.sy      = dv_pay.sy;
    al_nxt.clamped = dv_pay.clamped;
    al_nxt.stop    = dv_pay.stop;
    al_nxt.zero    = dv_pay.zero;
  end

  logic        a1_vld_r;
  al_pay_t     a1_pay_r;
  logic [31:0] a1_s0_r;
  logic [63:0] a1_pl_r [LANES];
  logic [63:0] a1_ph_r [LANES];

  // ---------------- a2: full product, cap test, divider split
  logic            a2_vld_r;
  al_pay_t         a2_pay_r;
  logic [31:0]     a2_s0_r;
  logic [31:0]     a2_rem_r [LANES];
  logic [CAP_BITS-1:0] a2_num_r [LANES];
  logic            a2_cap_r [LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a1_vld_r <= 1'b0;
      a2_vld_r <= 1'b0;
    end else if (adv) begin
      a1_vld_r <= dv_vld;
      a2_vld_r <= a1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_pay_r <= al_nxt;
      a1_s0_r  <= dv_pay.s0;
      a2_pay_r <= a1_pay_r;
      a2_s0_r  <= a1_s0_r;
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_prod
    logic [95:0] full;

    assign full = 96'(a1_pl_r[i]) + (96'(a1_ph_r[i]) << 32);

    always_ff @(posedge clk) begin
      if (adv) begin
        a1_pl_r[i]  <= 64'(ln_m[i]) * 64'(ln_d[i][31:0]);
        a1_ph_r[i]  <= 64'(ln_m[i]) * 64'(ln_d[i][63:32]);
        // quotient would need more than CAP_BITS bits
        a2_cap_r[i] <= (full[95:CAP_BITS] >= (96 - CAP_BITS)'(a1_s0_r));
        a2_rem_r[i] <= full[CAP_BITS +: 32];
        a2_num_r[i] <= full[CAP_BITS-1:0];
      end
    end
  end

  // ---------------- lane dividers by s0
  logic                ln_vld [LANES];
  logic [CAP_BITS-1:0] ln_q   [LANES];
  logic                ln_cap [LANES];
  al_pay_t             ln_pay;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    if (i == 0) begin : g_main
      logic [AL_PW:0] pin, pout;

      assign pin = {a2_pay_r, a2_cap_r[0]};

      bmp_div #(.QW(CAP_BITS), .DW(32), .PW(AL_PW + 1)) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (a2_vld_r),
        .in_rem  (a2_rem_r[0]),
        .in_num  (a2_num_r[0]),
        .in_den  (a2_s0_r),
        .in_pay  (pin),
        .out_vld (ln_vld[0]),
        .out_quo (ln_q[0]),
        .out_pay (pout)
      );
      assign ln_cap[0] = pout[0];
      assign ln_pay    = pout[AL_PW:1];
    end else begin : g_side
      bmp_div #(.QW(CAP_BITS), .DW(32), .PW(1)) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (a2_vld_r),
        .in_rem  (a2_rem_r[i]),
        .in_num  (a2_num_r[i]),
        .in_den  (a2_s0_r),
        .in_pay  (a2_cap_r[i]),
        .out_vld (ln_vld[i]),
        .out_quo (ln_q[i]),
        .out_pay (ln_cap[i])
      );
    end
  end

  // ---------------- output: sign, add, saturate
  logic signed [35:0] smag [LANES];
  logic               ln_neg [LANES];
  logic [31:0]        res_vx, res_vy, res_px, res_py;

  assign ln_neg[0] = ln_pay.sx;
  assign ln_neg[1] = ln_pay.sy;
  assign ln_neg[2] = ln_pay.sx;
  assign ln_neg[3] = ln_pay.sy;

  for (genvar i = 0; i < LANES; i++) begin : g_sign
    logic [CAP_BITS:0] mag;

    assign mag     = ln_cap[i] ? ((CAP_BITS + 1)'(1) << CAP_BITS)
                               : (CAP_BITS + 1)'(ln_q[i]);
    assign smag[i] = ln_neg[i] ? -$signed(36'(mag)) : $signed(36'(mag));
  end

  always_comb begin
    if (ln_pay.zero) begin
      res_px = ln_pay.px;
      res_py = ln_pay.py;
      res_vx = 32'd0;
      res_vy = 32'd0;
    end else begin
      res_vx = sat32(smag[0]);
      res_vy = sat32(smag[1]);
      res_px = sat32(36'(ln_pay.px) + smag[2]);
      res_py = sat32(36'(ln_pay.py) + smag[3]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= ln_vld[0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= {res_vy, res_vx, res_py, res_px};
      out_tuser_r <= {ln_pay.stop | ln_pay.zero, ln_pay.clamped};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // ---------------- checks
  logic lanes_in_step;

  assign lanes_in_step = (ln_vld[0] == ln_vld[1]) && (ln_vld[0] == ln_vld[2]) &&
                         (ln_vld[0] == ln_vld[3]);

  `BMP_ASSERT_IMP(a_lane_sync, clk, rst_n, 1'b1, lanes_in_step, "lane dividers out of step")
  `BMP_ASSERT_NXT(a_stall_hold, clk, rst_n, !adv, $stable(ln_vld[0]) && $stable(t3_vld_r), "pipeline moved during stall")
  `BMP_ASSERT_IMP(a_stop_still, clk, rst_n, out_tvalid_r && out_tuser_r[1], out_tdata_r[127:64] == 64'd0, "stopped word with nonzero velocity")

endmodule
